FILE: hw/rtl/multi_stack_delete_by_value_macros.svh
// Assertion helpers for the file that carries the concurrent checks.
// Each macro samples on aclk and is switched off while aresetn is low.
`ifndef MULTI_STACK_DELETE_BY_VALUE_MACROS_SVH
`define MULTI_STACK_DELETE_BY_VALUE_MACROS_SVH

// Same-cycle implication.
`define MSDBV_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSDBV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/msdbv_pkg.sv
package msdbv_pkg;

    // Bank geometry.
    localparam int NUM_STACKS  = 10;
    localparam int STACK_DEPTH = 16;
    localparam int VALUE_BITS  = 16;

    localparam int SIDX_W    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int IDX_W     = $clog2(STACK_DEPTH);
    localparam int DEPTH_W   = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Fixed field widths of the stream payloads.
    localparam int ACTION_W    = 2;
    localparam int STACK_IDX_W = 4;
    localparam int VALUE_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_OUT_W = 5;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic shift;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic start_scan;
        logic hit;
        logic miss_end;
        logic shift_end;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: hw/rtl/msdbv_datapath.sv
module msdbv_datapath (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic [msdbv_pkg::ACTION_W-1:0]              in_action,
    input  logic [msdbv_pkg::STACK_IDX_W-1:0]           in_stack_index,
    input  logic signed [msdbv_pkg::VALUE_W-1:0]        in_value,
    input  msdbv_pkg::ctrl_cmd_t                        cmd,
    output msdbv_pkg::dp_stat_t                         stat,
    output logic [msdbv_pkg::M_TDATA_W-1:0]             m_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready
);
    import msdbv_pkg::*;

    // Entry storage: one row of STACK_DEPTH words per stack, bottom at index 0.
    logic [VALUE_BITS-1:0] mem [MEM_DEPTH];

    // Operation registers.
    logic [ACTION_W-1:0]    act_reg;
    logic [STACK_IDX_W-1:0] stk_reg;
    logic [VALUE_BITS-1:0]  val_reg;
    logic signed [31:0]     val_ext;

    // Per-stack fill counts.
    logic [DEPTH_W-1:0] depth_reg [NUM_STACKS];
    logic               depth_wr_en;
    logic [DEPTH_W-1:0] depth_wr_val;

    // Walk control.
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [DEPTH_W-1:0] ptr_reg, ptr_next;
    logic               more_reg, more_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [VALUE_BITS-1:0] rd_data_reg;

    // Memory ports.
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx_issue;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [VALUE_BITS-1:0] wr_data;

    // Result and output registers.
    logic               res_set;
    status_t            res_status_new, res_status_reg;
    logic [DEPTH_W-1:0] res_depth_new, res_depth_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic               m_tvalid_reg, m_tvalid_next;

    logic               stk_ok;
    logic [SIDX_W-1:0]  sidx;
    logic [DEPTH_W-1:0] depth_cur;
    logic [DEPTH_W-1:0] hit_next_ptr;
    logic               hit;
    logic               miss_end;
    logic               shift_end;
    logic               start_scan;

    function automatic logic [ADDR_W-1:0] ent_addr(input logic [SIDX_W-1:0] s,
                                                   input logic [IDX_W-1:0]  i);
        return ADDR_W'(ADDR_W'(s) * ADDR_W'(STACK_DEPTH) + ADDR_W'(i));
    endfunction

    // Sign-extend the incoming id and keep the stored width.
    assign val_ext = 32'(in_value);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= in_action;
            stk_reg <= in_stack_index;
            val_reg <= val_ext[VALUE_BITS-1:0];
        end
    end

    // Addressed stack and its current depth.
    assign stk_ok    = (32'(stk_reg) < NUM_STACKS);
    assign sidx      = SIDX_W'(stk_reg);
    assign depth_cur = stk_ok ? depth_reg[sidx] : '0;

    assign hit          = rd_vld_reg && (rd_data_reg == val_reg);
    assign miss_end     = rd_vld_reg && !hit && (rd_idx_reg == '0);
    assign shift_end    = !more_reg && !rd_vld_reg;
    assign start_scan   = stk_ok && (act_reg == ACT_REMOVE) && (depth_cur != '0);
    assign hit_next_ptr = DEPTH_W'(rd_idx_reg) + DEPTH_W'(1);

    // Step logic for execute, scan and shift.
    always_comb begin
        wr_en          = 1'b0;
        wr_idx         = '0;
        wr_data        = val_reg;
        rd_en          = 1'b0;
        rd_idx_issue   = '0;
        scan_idx_next  = scan_idx_reg;
        ptr_next       = ptr_reg;
        more_next      = more_reg;
        rd_vld_next    = 1'b0;
        res_set        = 1'b0;
        res_status_new = ST_DONE;
        res_depth_new  = '0;
        depth_wr_en    = 1'b0;
        depth_wr_val   = '0;

        if (cmd.exec) begin
            if (start_scan) begin
                scan_idx_next = IDX_W'(depth_cur - DEPTH_W'(1));
                more_next     = 1'b1;
            end else begin
                res_set = 1'b1;
                if (stk_ok) begin
                    case (act_reg)
                        ACT_PUSH: begin
                            if (depth_cur >= DEPTH_W'(STACK_DEPTH)) begin
                                res_status_new = ST_FULL;
                                res_depth_new  = depth_cur;
                            end else begin
                                wr_en         = 1'b1;
                                wr_idx        = IDX_W'(depth_cur);
                                depth_wr_en   = 1'b1;
                                depth_wr_val  = depth_cur + DEPTH_W'(1);
                                res_depth_new = depth_cur + DEPTH_W'(1);
                            end
                        end
                        ACT_REMOVE: begin
                            // Empty stack: nothing to find.
                            res_status_new = ST_ABSENT;
                            res_depth_new  = depth_cur;
                        end
                        ACT_CLEAR: begin
                            depth_wr_en = 1'b1;
                        end
                        default: begin
                            res_depth_new = depth_cur;
                        end
                    endcase
                end
            end
        end

        // Scan from the top down, one read issued per cycle.
        if (cmd.scan) begin
            if (more_reg) begin
                rd_en        = 1'b1;
                rd_idx_issue = scan_idx_reg;
                rd_vld_next  = 1'b1;
                if (scan_idx_reg == '0) begin
                    more_next = 1'b0;
                end else begin
                    scan_idx_next = scan_idx_reg - IDX_W'(1);
                end
            end
            if (hit) begin
                rd_vld_next = 1'b0;
                ptr_next    = hit_next_ptr;
                more_next   = (hit_next_ptr < depth_cur);
            end else if (miss_end) begin
                res_set        = 1'b1;
                res_status_new = ST_ABSENT;
                res_depth_new  = depth_cur;
            end
        end

        // Move every entry above the hit down by one place.
        if (cmd.shift) begin
            if (more_reg) begin
                rd_en        = 1'b1;
                rd_idx_issue = IDX_W'(ptr_reg);
                rd_vld_next  = 1'b1;
                ptr_next     = ptr_reg + DEPTH_W'(1);
                more_next    = ((ptr_reg + DEPTH_W'(1)) < depth_cur);
            end
            if (rd_vld_reg) begin
                wr_en   = 1'b1;
                wr_idx  = rd_idx_reg - IDX_W'(1);
                wr_data = rd_data_reg;
            end
            if (shift_end) begin
                depth_wr_en   = 1'b1;
                depth_wr_val  = depth_cur - DEPTH_W'(1);
                res_set       = 1'b1;
                res_depth_new = depth_cur - DEPTH_W'(1);
            end
        end
    end

    // Entry memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[ent_addr(sidx, wr_idx)] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[ent_addr(sidx, rd_idx_issue)];
            rd_idx_reg  <= rd_idx_issue;
        end
    end

    // Fill counts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                depth_reg[i] <= '0;
            end
        end else if (depth_wr_en) begin
            depth_reg[sidx] <= depth_wr_val;
        end
    end

    // Walk registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            more_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
        end else begin
            more_reg   <= more_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        ptr_reg      <= ptr_next;
    end

    // Result holding register.
    always_ff @(posedge aclk) begin
        if (res_set) begin
            res_status_reg <= res_status_new;
            res_depth_reg  <= res_depth_new;
        end
    end

    // Output register: a finished result waits here for its transfer.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= M_TDATA_W'({DEPTH_OUT_W'(res_depth_reg), res_status_reg});
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    assign stat.start_scan = start_scan;
    assign stat.hit        = hit;
    assign stat.miss_end   = miss_end;
    assign stat.shift_end  = shift_end;
    assign stat.out_free   = !m_tvalid_reg || m_tready;

endmodule

FILE: hw/rtl/msdbv_ctrl.sv
module msdbv_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  msdbv_pkg::dp_stat_t   stat,
    output msdbv_pkg::ctrl_cmd_t  cmd
);
    import msdbv_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.start_scan ? S_SCAN : S_RESP;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.hit) begin
                    state_next = S_SHIFT;
                end else if (stat.miss_end) begin
                    state_next = S_RESP;
                end
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (stat.shift_end) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/multi_stack_delete_by_value.sv
// Bank of NUM_STACKS bounded stacks of container ids, each up to STACK_DEPTH deep, held in
// one entry memory with a single read and a single write port. Each input transfer names
// an action (push, remove by value, clear), a stack and a value, and gives exactly one
// result transfer with a status and the stack's depth afterwards. Items are handled one at
// a time; the next item is taken as soon as the previous result sits in the output register.
// Push, clear and requests for a stack outside the bank go from execute straight to the result.
// A remove walks the memory one entry per cycle: it scans down from the top to the topmost
// match and then moves each entry above it down by one place; an absent value is scanned
// down to the bottom entry.
// The entry memory needs no clearing after reset.
`include "multi_stack_delete_by_value_macros.svh"

module multi_stack_delete_by_value (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: stack_index [3:0], value [19:4], zero [23:20]
    input  logic [msdbv_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: action [1:0]
    input  logic [msdbv_pkg::ACTION_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: status [1:0], depth_after [6:2], zero [7]
    output logic [msdbv_pkg::M_TDATA_W-1:0]     m_tdata
);
    import msdbv_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    logic [STACK_IDX_W-1:0]  in_stack_index;
    logic signed [VALUE_W-1:0] in_value;

    // Unpack the input payload.
    assign in_stack_index = s_tdata[STACK_IDX_W-1:0];
    assign in_value       = s_tdata[STACK_IDX_W+VALUE_W-1:STACK_IDX_W];

    msdbv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    msdbv_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_action      (s_tuser),
        .in_stack_index (in_stack_index),
        .in_value       (in_value),
        .cmd            (cmd),
        .stat           (stat),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready)
    );

    // Only one item is in work at a time.
    `MSDBV_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken")
    // A result is loaded only when the output register is free.
    `MSDBV_ASSERT_IMPL(a_out_slot, cmd.out_load, !m_tvalid || m_tready, "result overwritten")
    // The controller issues at most one command per cycle.
    `MSDBV_ASSERT_IMPL(a_cmd_single, 1'b1, $onehot0(cmd), "overlapping commands")
    // A scan hit is followed by the shift phase.
    `MSDBV_ASSERT_NEXT(a_hit_shift, cmd.scan && stat.hit, cmd.shift, "hit not followed by shift")

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import msdbv_pkg::*;

    // Action code that the package leaves unnamed; the block must treat it as a no-op.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int MAX_GAP = 18;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 8;
    localparam int RANDOM_ITEMS = 1775;

    typedef struct {
        status_t            status;
        logic [DEPTH_OUT_W-1:0] depth_after;
    } stack_reply_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [ACTION_W-1:0]    s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    // Shadow copy of the stack bank, updated as each request is accepted.
    logic [VALUE_BITS-1:0]  shadow_entries [NUM_STACKS][STACK_DEPTH];
    int                     shadow_depth [NUM_STACKS];
    stack_reply_t           pending_stack_replies [$];

    int  fail_count;
    int  quiet_cycles;
    bit  sender_idle;
    bit  receiver_idle;

    logic [VALUE_W-1:0] value_pool [0:7] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
                                             16'h0001, 16'h00A5, 16'h5A5A, 16'hC3C3};

    multi_stack_delete_by_value u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock, 12 ns period.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Apply one accepted request to the shadow bank and queue the reply it must produce.
    function automatic void apply_stack_op(logic [ACTION_W-1:0] act,
                                           logic [STACK_IDX_W-1:0] sidx,
                                           logic [VALUE_W-1:0] val);
        stack_reply_t          reply;
        logic [VALUE_BITS-1:0] v;
        int                    d;
        int                    k;
        int                    hit;
        reply.status = ST_DONE;
        reply.depth_after = '0;
        v = val[VALUE_BITS-1:0];
        if (sidx < NUM_STACKS) begin
            d = shadow_depth[sidx];
            case (act)
                ACT_PUSH: begin
                    if (d >= STACK_DEPTH) begin
                        reply.status = ST_FULL;
                    end else begin
                        shadow_entries[sidx][d] = v;
                        shadow_depth[sidx] = d + 1;
                    end
                end
                ACT_REMOVE: begin
                    // Find the topmost match, then close the gap above it.
                    hit = -1;
                    for (k = d - 1; k >= 0 && hit < 0; k--) begin
                        if (shadow_entries[sidx][k] == v) hit = k;
                    end
                    if (hit < 0) begin
                        reply.status = ST_ABSENT;
                    end else begin
                        for (k = hit; k + 1 < d; k++) begin
                            shadow_entries[sidx][k] = shadow_entries[sidx][k + 1];
                        end
                        shadow_depth[sidx] = d - 1;
                    end
                end
                ACT_CLEAR: shadow_depth[sidx] = 0;
                default: ;
            endcase
            reply.depth_after = shadow_depth[sidx][DEPTH_OUT_W-1:0];
        end
        pending_stack_replies.push_back(reply);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch: %s got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Offer one request, after a random gap when the sender idles, and hold it until the block takes it.
    task automatic send_request(logic [ACTION_W-1:0] act, logic [STACK_IDX_W-1:0] sidx,
                                logic [VALUE_W-1:0] val);
        int gap;
        gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W - VALUE_W - STACK_IDX_W){1'b0}}, val, sidx};
        do @(posedge aclk); while (!s_tready);
        apply_stack_op(act, sidx, val);
    endtask

    // Result side: a random stall before each transfer, sometimes none at all.
    initial begin : reply_ready_drive
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Check every result transfer against the oldest queued reply; track idle cycles.
    always @(posedge aclk) begin
        stack_reply_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (m_tvalid && m_tready) begin
                if (pending_stack_replies.size() == 0) begin
                    report_mismatch("result with no request pending, m_tdata", m_tdata, 0);
                end else begin
                    want = pending_stack_replies.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("status", m_tdata[1:0], want.status);
                    if (m_tdata[6:2] !== want.depth_after)
                        report_mismatch("depth_after", m_tdata[6:2], want.depth_after);
                    if (m_tdata[7] !== 1'b0)
                        report_mismatch("pad bit", m_tdata[7], 0);
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either side ends the run.
    initial begin : quiet_watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("tb_top: FAIL");
        $finish;
    end

    // Fill one stack with extreme and repeated values, then push once more onto it.
    task automatic test_fill_to_full();
        int i;
        for (i = 0; i < STACK_DEPTH; i++) begin
            send_request(ACT_PUSH, 4'd9, value_pool[i % 8]);
        end
        send_request(ACT_PUSH, 4'd9, 16'h1234);
    endtask

    // Remove a repeated value (topmost copy goes), an absent value, and from an empty stack.
    task automatic test_remove_cases();
        send_request(ACT_REMOVE, 4'd9, 16'h8000);
        send_request(ACT_REMOVE, 4'd9, 16'h4321);
        send_request(ACT_REMOVE, 4'd0, 16'h0000);
    endtask

    // Unused action code and stack indexes outside the bank.
    task automatic test_odd_requests();
        send_request(ACT_UNUSED, 4'd9, 16'hFFFF);
        send_request(ACT_PUSH, 4'd15, 16'h7FFF);
        send_request(ACT_REMOVE, 4'(NUM_STACKS), 16'h8000);
    endtask

    // Clear a loaded stack, then clear it again while empty.
    task automatic test_clear();
        send_request(ACT_CLEAR, 4'd9, 16'hAAAA);
        send_request(ACT_CLEAR, 4'd9, 16'h5555);
    endtask

    // Random traffic in segments: each segment works mostly on two stacks so that they fill
    // and drain, and draws its own mix of pushes and removes and its own idling.
    task automatic test_random_traffic();
        int n;
        int r;
        int hot_a;
        int hot_b;
        int push_pct;
        int d;
        logic [ACTION_W-1:0]    act;
        logic [STACK_IDX_W-1:0] sidx;
        logic [VALUE_W-1:0]     val;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 120 == 0) begin
                hot_a = $urandom_range(0, NUM_STACKS - 1);
                hot_b = $urandom_range(0, NUM_STACKS - 1);
                push_pct = ($urandom_range(0, 1) == 1) ? 70 : 35;
                sender_idle = ($urandom_range(0, 3) != 0);
                receiver_idle = ($urandom_range(0, 3) != 0);
            end
            // Pick the stack.
            r = $urandom_range(0, 99);
            if (r < 4) sidx = 4'($urandom_range(NUM_STACKS, 15));
            else if (r < 44) sidx = 4'(hot_a);
            else if (r < 84) sidx = 4'(hot_b);
            else sidx = 4'($urandom_range(0, NUM_STACKS - 1));
            // Pick the action.
            r = $urandom_range(0, 99);
            if (r < 3) act = ACT_CLEAR;
            else if (r < 5) act = ACT_UNUSED;
            else if (r < push_pct) act = ACT_PUSH;
            else act = ACT_REMOVE;
            // Pick the value: removes mostly target an entry that is present.
            d = (sidx < NUM_STACKS) ? shadow_depth[sidx] : 0;
            r = $urandom_range(0, 99);
            if (act == ACT_REMOVE && d > 0 && r < 70)
                val = shadow_entries[sidx][$urandom_range(0, d - 1)];
            else if (r < 85)
                val = value_pool[$urandom_range(0, 7)];
            else
                val = 16'($urandom);
            send_request(act, sidx, val);
        end
    endtask

    // Stop offering requests, wait for every reply, then let the block settle.
    task automatic drain_replies();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_stack_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        fail_count    = 0;
        quiet_cycles  = 0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        for (int s = 0; s < NUM_STACKS; s++) shadow_depth[s] = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_fill_to_full();
        test_remove_cases();
        test_odd_requests();
        test_clear();
        test_random_traffic();
        drain_replies();

        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

FILE: multi_stack_delete_by_value.f
+incdir+hw/rtl
hw/rtl/msdbv_pkg.sv
hw/rtl/msdbv_datapath.sv
hw/rtl/msdbv_ctrl.sv
hw/rtl/multi_stack_delete_by_value.sv
dv/tb_top.sv
